// ===== src/color_grid_test_pattern_macros.svh =====
// Assertion shorthands for the color grid test pattern block.
// Every check samples on the rising clock edge and is muted during reset.
`ifndef COLOR_GRID_TEST_PATTERN_MACROS_SVH
`define COLOR_GRID_TEST_PATTERN_MACROS_SVH

// Check a property that holds on every clock edge outside reset.
`define CGTP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Check that a cause on one edge is followed by an effect on the next edge.
`define CGTP_ASSERT_NEXT(label, cause, effect, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cause) |=> (effect)) \
      else $error(msg);

`endif

// ===== src/cgtp_pkg.sv =====
package cgtp_pkg;

   localparam int COORD_BITS_DEFAULT = 11;
   localparam int RES_BITS           = 11;
   localparam int BYTES_BITS         = 3;
   localparam int DEPTH_BITS         = 6;
   localparam int CELL_BITS          = 8;
   localparam int COLOR_BITS         = 32;
   localparam int STEP_BITS          = 8;
   localparam int LAYOUT_BITS        = 30;
   localparam int FIELD_BITS         = 5;
   localparam int ADDR_BITS          = 24;
   localparam int INDEX_BITS         = 2 * CELL_BITS;
   localparam int INDEX_STEP_BITS    = INDEX_BITS + STEP_BITS;
   localparam int CSR_INDEX_BITS     = 3;
   localparam int CSR_DATA_BITS      = 32;
   localparam int DIV_COUNT_BITS     = $clog2(RES_BITS + 1);
   localparam int MAX_FIELD_SIZE     = 8;

   localparam logic [BYTES_BITS-1:0] INDEXED_BYTES = BYTES_BITS'(1);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SCREEN_WIDTH    = 3'd0,
      CSR_Y_RESOLUTION    = 3'd1,
      CSR_PIXEL_BYTES     = 3'd2,
      CSR_BITS_PER_PIXEL  = 3'd3,
      CSR_CELL_COUNT      = 3'd4,
      CSR_FIRST_COLOR     = 3'd5,
      CSR_COLOR_STEP      = 3'd6,
      CSR_FIELD_LAYOUT    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [RES_BITS-1:0]    screen_width;
      logic [RES_BITS-1:0]    y_resolution;
      logic [BYTES_BITS-1:0]  pixel_bytes;
      logic [DEPTH_BITS-1:0]  bits_per_pixel;
      logic [CELL_BITS-1:0]   cell_count;
      logic [COLOR_BITS-1:0]  first_color;
      logic [STEP_BITS-1:0]   color_step;
      logic [LAYOUT_BITS-1:0] field_layout;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      screen_width:    RES_BITS'(1024),
      y_resolution:    RES_BITS'(768),
      pixel_bytes:     BYTES_BITS'(3),
      bits_per_pixel:  DEPTH_BITS'(24),
      cell_count:      CELL_BITS'(8),
      first_color:     COLOR_BITS'(0),
      color_step:      STEP_BITS'(1),
      field_layout:    LAYOUT_BITS'(268706064)
   };

   function automatic logic [COLOR_BITS-1:0] low_mask(input logic [DEPTH_BITS-1:0] bits);
      logic [COLOR_BITS-1:0] mask;
      if (bits >= DEPTH_BITS'(COLOR_BITS)) begin
         mask = '1;
      end else begin
         mask = (COLOR_BITS'(1) << bits) - COLOR_BITS'(1);
      end
      return mask;
   endfunction

   // One color field of the base color, advanced and wrapped at its own size, clipped to at most 8 bits.
   function automatic logic [COLOR_BITS-1:0] channel_bits(
      input logic [COLOR_BITS-1:0] first,
      input logic [FIELD_BITS-1:0] pos,
      input logic [FIELD_BITS-1:0] size,
      input logic [STEP_BITS-1:0]  advance
   );
      logic [DEPTH_BITS-1:0] clipped;
      logic [COLOR_BITS-1:0] mask;
      logic [COLOR_BITS-1:0] value;
      clipped = (size > FIELD_BITS'(MAX_FIELD_SIZE)) ? DEPTH_BITS'(MAX_FIELD_SIZE)
                                                      : DEPTH_BITS'(size);
      mask  = low_mask(clipped);
      value = ((first >> pos) & mask) + COLOR_BITS'(advance);
      return (value & mask) << pos;
   endfunction

endpackage

// ===== src/cgtp_cfg_div.sv =====
module cgtp_cfg_div import cgtp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [RES_BITS-1:0]  screen_width,
   input  logic [RES_BITS-1:0]  y_resolution,
   input  logic [CELL_BITS-1:0] cell_count,
   output logic [RES_BITS-1:0]  cell_width,
   output logic [RES_BITS-1:0]  cell_height,
   output logic                 busy
);

   localparam logic [DIV_COUNT_BITS-1:0] DIV_STEPS = DIV_COUNT_BITS'(RES_BITS);

   logic                      busy_ff;
   logic [DIV_COUNT_BITS-1:0] count_ff;
   logic [CELL_BITS-1:0]      rem_x_ff, rem_y_ff;
   logic [RES_BITS-1:0]       quo_x_ff, quo_y_ff;
   logic [RES_BITS-1:0]       width_ff, height_ff;

   logic [CELL_BITS:0]        shift_x, shift_y;
   logic                      ge_x, ge_y;
   logic [CELL_BITS-1:0]      rem_x_in, rem_y_in;
   logic [RES_BITS-1:0]       quo_x_in, quo_y_in;

   // one restoring step per cycle for both lanes
   always_comb begin
      shift_x  = {rem_x_ff, quo_x_ff[RES_BITS-1]};
      shift_y  = {rem_y_ff, quo_y_ff[RES_BITS-1]};
      ge_x     = shift_x >= {1'b0, cell_count};
      ge_y     = shift_y >= {1'b0, cell_count};
      rem_x_in = ge_x ? CELL_BITS'(shift_x - {1'b0, cell_count}) : shift_x[CELL_BITS-1:0];
      rem_y_in = ge_y ? CELL_BITS'(shift_y - {1'b0, cell_count}) : shift_y[CELL_BITS-1:0];
      quo_x_in = {quo_x_ff[RES_BITS-2:0], ge_x};
      quo_y_in = {quo_y_ff[RES_BITS-2:0], ge_y};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         count_ff <= '0;
      end else if (start) begin
         busy_ff  <= 1'b1;
         count_ff <= '0;
      end else if (busy_ff) begin
         count_ff <= count_ff + DIV_COUNT_BITS'(1);
         if (count_ff == DIV_STEPS) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff && !start) begin
         if (count_ff == '0) begin
            rem_x_ff <= '0;
            rem_y_ff <= '0;
            quo_x_ff <= screen_width;
            quo_y_ff <= y_resolution;
         end else begin
            rem_x_ff <= rem_x_in;
            rem_y_ff <= rem_y_in;
            quo_x_ff <= quo_x_in;
            quo_y_ff <= quo_y_in;
         end
         if (count_ff == DIV_STEPS) begin
            width_ff  <= quo_x_in;
            height_ff <= quo_y_in;
         end
      end
   end

   assign cell_width  = width_ff;
   assign cell_height = height_ff;
   assign busy        = busy_ff;

endmodule

// ===== src/cgtp_div_pipe.sv =====
module cgtp_div_pipe import cgtp_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [RES_BITS-1:0]   cell_width,
   input  logic [RES_BITS-1:0]   cell_height,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [COORD_BITS-1:0] in_x,
   input  logic [COORD_BITS-1:0] in_y,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [COORD_BITS-1:0] out_x,
   output logic [COORD_BITS-1:0] out_y,
   output logic [COORD_BITS-1:0] out_col,
   output logic [COORD_BITS-1:0] out_row
);

   localparam int STAGES = COORD_BITS;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] qx;
      logic [COORD_BITS-1:0] qy;
      logic [RES_BITS-1:0]   rx;
      logic [RES_BITS-1:0]   ry;
   } div_stage_type;

   div_stage_type     stage_src [STAGES];
   div_stage_type     stage_in  [STAGES];
   div_stage_type     stage_ff  [STAGES];
   logic [STAGES-1:0] src_valid;
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] stage_ready;

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic [RES_BITS:0] shift_x, shift_y;
      logic              ge_x, ge_y;

      if (i == 0) begin : g_head
         assign stage_src[i] = '{x: in_x, y: in_y, qx: '0, qy: '0, rx: '0, ry: '0};
         assign src_valid[i] = in_valid;
      end else begin : g_body
         assign stage_src[i] = stage_ff[i-1];
         assign src_valid[i] = valid_ff[i-1];
      end

      if (i == STAGES - 1) begin : g_tail
         assign stage_ready[i] = !valid_ff[i] || out_ready;
      end else begin : g_link
         assign stage_ready[i] = !valid_ff[i] || stage_ready[i+1];
      end

      // one quotient bit per stage, most significant first
      assign shift_x = {stage_src[i].rx, stage_src[i].x[COORD_BITS-1-i]};
      assign shift_y = {stage_src[i].ry, stage_src[i].y[COORD_BITS-1-i]};
      assign ge_x    = shift_x >= {1'b0, cell_width};
      assign ge_y    = shift_y >= {1'b0, cell_height};

      always_comb begin
         stage_in[i]    = stage_src[i];
         stage_in[i].rx = ge_x ? RES_BITS'(shift_x - {1'b0, cell_width})
                              : shift_x[RES_BITS-1:0];
         stage_in[i].ry = ge_y ? RES_BITS'(shift_y - {1'b0, cell_height})
                              : shift_y[RES_BITS-1:0];
         stage_in[i].qx = {stage_src[i].qx[COORD_BITS-2:0], ge_x};
         stage_in[i].qy = {stage_src[i].qy[COORD_BITS-2:0], ge_y};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (stage_ready[i]) begin
            valid_ff[i] <= src_valid[i];
         end
      end

      always_ff @(posedge clock) begin
         if (stage_ready[i] && src_valid[i]) begin
            stage_ff[i] <= stage_in[i];
         end
      end
   end

   assign in_ready  = stage_ready[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_x     = stage_ff[STAGES-1].x;
   assign out_y     = stage_ff[STAGES-1].y;
   assign out_col   = stage_ff[STAGES-1].qx;
   assign out_row   = stage_ff[STAGES-1].qy;

endmodule

// ===== src/cgtp_color_pipe.sv =====
module cgtp_color_pipe import cgtp_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic [RES_BITS-1:0]   cell_width,
   input  logic [RES_BITS-1:0]   cell_height,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [COORD_BITS-1:0] in_x,
   input  logic [COORD_BITS-1:0] in_y,
   input  logic [COORD_BITS-1:0] in_col,
   input  logic [COORD_BITS-1:0] in_row,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic                  out_covered,
   output logic [ADDR_BITS-1:0]  out_address,
   output logic [COLOR_BITS-1:0] out_color
);

   localparam int PROD_BITS = COORD_BITS + RES_BITS;

   logic ready1, ready2, ready3, ready4;

   // stage 1: coverage and the small products
   logic                       s1_valid_ff;
   logic                       s1_hit_ff,      s1_hit_in;
   logic [COORD_BITS-1:0]      s1_x_ff;
   logic [CELL_BITS-1:0]       s1_col_ff;
   logic [PROD_BITS-1:0]       s1_yx_ff,       s1_yx_in;
   logic [STEP_BITS-1:0]       s1_colstep_ff,  s1_colstep_in;
   logic [STEP_BITS-1:0]       s1_rowstep_ff,  s1_rowstep_in;
   logic [INDEX_BITS-1:0]      s1_rowcc_ff,    s1_rowcc_in;

   // stage 2: linear pixel index and cell index
   logic                       s2_valid_ff;
   logic                       s2_hit_ff;
   logic [ADDR_BITS-1:0]       s2_linear_ff,   s2_linear_in;
   logic [INDEX_BITS-1:0]      s2_index_ff,    s2_index_in;
   logic [STEP_BITS-1:0]       s2_adv_r_ff, s2_adv_g_ff;
   logic [STEP_BITS-1:0]       s2_adv_b_ff,    s2_adv_b_in;

   // stage 3: byte address and indexed increment
   logic                       s3_valid_ff;
   logic                       s3_hit_ff;
   logic [ADDR_BITS-1:0]       s3_address_ff,  s3_address_in;
   logic [INDEX_STEP_BITS-1:0] s3_idxstep_ff,  s3_idxstep_in;
   logic [STEP_BITS-1:0]       s3_adv_r_ff, s3_adv_g_ff, s3_adv_b_ff;

   // stage 4: output register
   logic                       s4_valid_ff;
   logic                       s4_covered_ff;
   logic [ADDR_BITS-1:0]       s4_address_ff;
   logic [COLOR_BITS-1:0]      s4_color_ff,    s4_color_in;
   logic [COLOR_BITS-1:0]      direct_color, indexed_color;

   assign ready4   = !s4_valid_ff || out_ready;
   assign ready3   = !s3_valid_ff || ready4;
   assign ready2   = !s2_valid_ff || ready3;
   assign ready1   = !s1_valid_ff || ready2;
   assign in_ready = ready1;

   always_comb begin
      s1_hit_in = (cfg.cell_count != '0) && (cell_width != '0) && (cell_height != '0) &&
                  (in_col < COORD_BITS'(cfg.cell_count)) &&
                  (in_row < COORD_BITS'(cfg.cell_count));
      s1_yx_in      = PROD_BITS'(in_y) * PROD_BITS'(cfg.screen_width);
      s1_colstep_in = STEP_BITS'(in_col[CELL_BITS-1:0] * cfg.color_step);
      s1_rowstep_in = STEP_BITS'(in_row[CELL_BITS-1:0] * cfg.color_step);
      s1_rowcc_in   = INDEX_BITS'(in_row[CELL_BITS-1:0]) * INDEX_BITS'(cfg.cell_count);
   end

   always_comb begin
      s2_linear_in = ADDR_BITS'(s1_yx_ff + PROD_BITS'(s1_x_ff));
      s2_index_in  = s1_rowcc_ff + INDEX_BITS'(s1_col_ff);
      s2_adv_b_in  = s1_colstep_ff + s1_rowstep_ff;
   end

   always_comb begin
      s3_address_in = ADDR_BITS'(cfg.pixel_bytes) * s2_linear_ff;
      s3_idxstep_in = INDEX_STEP_BITS'(s2_index_ff) * INDEX_STEP_BITS'(cfg.color_step);
   end

   always_comb begin
      indexed_color = cfg.first_color + COLOR_BITS'(s3_idxstep_ff);
      direct_color  =
         channel_bits(cfg.first_color, cfg.field_layout[4:0],   cfg.field_layout[9:5],
                      s3_adv_r_ff) |
         channel_bits(cfg.first_color, cfg.field_layout[14:10], cfg.field_layout[19:15],
                      s3_adv_g_ff) |
         channel_bits(cfg.first_color, cfg.field_layout[24:20], cfg.field_layout[29:25],
                      s3_adv_b_ff);
      if (!s3_hit_ff) begin
         s4_color_in = '0;
      end else if (cfg.pixel_bytes == INDEXED_BYTES) begin
         s4_color_in = indexed_color & low_mask(cfg.bits_per_pixel);
      end else begin
         s4_color_in = direct_color & low_mask(cfg.bits_per_pixel);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (ready1) s1_valid_ff <= in_valid;
         if (ready2) s2_valid_ff <= s1_valid_ff;
         if (ready3) s3_valid_ff <= s2_valid_ff;
         if (ready4) s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1 && in_valid) begin
         s1_hit_ff     <= s1_hit_in;
         s1_x_ff       <= in_x;
         s1_col_ff     <= in_col[CELL_BITS-1:0];
         s1_yx_ff      <= s1_yx_in;
         s1_colstep_ff <= s1_colstep_in;
         s1_rowstep_ff <= s1_rowstep_in;
         s1_rowcc_ff   <= s1_rowcc_in;
      end
      if (ready2 && s1_valid_ff) begin
         s2_hit_ff    <= s1_hit_ff;
         s2_linear_ff <= s2_linear_in;
         s2_index_ff  <= s2_index_in;
         s2_adv_r_ff  <= s1_colstep_ff;
         s2_adv_g_ff  <= s1_rowstep_ff;
         s2_adv_b_ff  <= s2_adv_b_in;
      end
      if (ready3 && s2_valid_ff) begin
         s3_hit_ff     <= s2_hit_ff;
         s3_address_ff <= s3_address_in;
         s3_idxstep_ff <= s3_idxstep_in;
         s3_adv_r_ff   <= s2_adv_r_ff;
         s3_adv_g_ff   <= s2_adv_g_ff;
         s3_adv_b_ff   <= s2_adv_b_ff;
      end
      if (ready4 && s3_valid_ff) begin
         s4_covered_ff <= s3_hit_ff;
         s4_address_ff <= s3_address_ff;
         s4_color_ff   <= s4_color_in;
      end
   end

   assign out_valid   = s4_valid_ff;
   assign out_covered = s4_covered_ff;
   assign out_address = s4_address_ff;
   assign out_color   = s4_color_ff;

endmodule

// ===== src/color_grid_test_pattern.sv =====
// Color grid test pattern: one pixel coordinate in, one pixel result out.
// Input items (req_) carry pixel_x and pixel_y; result items (rsp_) carry the
// covered flag on tuser, and the framebuffer byte address and masked color on
// tdata. Items leave in the order they arrive, exactly one result per item.
// The accepting edge loads the first of one stage per quotient bit of the
// column and row division, then four stages for products, address and color
// follow. Throughput is one item per cycle while the divider is idle and the
// receiver takes results; each pipeline stage holds one item.
// Configuration goes through csr_we / csr_addr / csr_wdata; the user must
// write it only while the block is idle, as the block itself does not enforce
// this. Every write, and reset, restarts a bit-serial divider that finds the
// cell width and height, and req_tready stays low until it finishes.
// Reset restores the default 1024x768, 3 bytes, 24 bit, 8x8 grid.
// When the receiver stalls, the output register holds its item and every stage
// fills its bubble before taking back pressure, so nothing is lost or repeated.
`include "color_grid_test_pattern_macros.svh"

module color_grid_test_pattern import cgtp_pkg::*; #(
   parameter  int COORD_BITS    = COORD_BITS_DEFAULT,
   localparam int REQ_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8,
   localparam int RSP_DATA_BITS = ADDR_BITS + COLOR_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   // input items
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // pixel_x, pixel_y, zero padding
   input  logic [REQ_DATA_BITS-1:0]      req_tdata,
   // result items
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // byte_address, pixel_color
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata,
   // covered
   output logic                          rsp_tuser,
   // configuration writes
   input  logic                          csr_we,
   input  logic [CSR_INDEX_BITS-1:0]     csr_addr,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam int CHECK_BITS    = RES_BITS + CELL_BITS + 1;

   cfg_type               cfg_ff, cfg_in;
   logic                  cfg_busy;
   logic [RES_BITS-1:0]   cell_width, cell_height;

   logic                  div_in_valid, div_in_ready;
   logic                  div_out_valid, div_out_ready;
   logic [COORD_BITS-1:0] div_x, div_y, div_col, div_row;

   logic [ADDR_BITS-1:0]  rsp_address;
   logic [COLOR_BITS-1:0] rsp_color;

   // decode configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_SCREEN_WIDTH:    cfg_in.screen_width    = csr_wdata[RES_BITS-1:0];
            CSR_Y_RESOLUTION:    cfg_in.y_resolution    = csr_wdata[RES_BITS-1:0];
            CSR_PIXEL_BYTES:     cfg_in.pixel_bytes     = csr_wdata[BYTES_BITS-1:0];
            CSR_BITS_PER_PIXEL:  cfg_in.bits_per_pixel  = csr_wdata[DEPTH_BITS-1:0];
            CSR_CELL_COUNT:      cfg_in.cell_count      = csr_wdata[CELL_BITS-1:0];
            CSR_FIRST_COLOR:     cfg_in.first_color     = csr_wdata[COLOR_BITS-1:0];
            CSR_COLOR_STEP:      cfg_in.color_step      = csr_wdata[STEP_BITS-1:0];
            CSR_FIELD_LAYOUT:    cfg_in.field_layout    = csr_wdata[LAYOUT_BITS-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // cell size = resolution / cell count, recomputed after reset and each write
   cgtp_cfg_div u_cfg_div (
      .clock        (clock),
      .reset        (reset),
      .start        (csr_we),
      .screen_width (cfg_ff.screen_width),
      .y_resolution (cfg_ff.y_resolution),
      .cell_count   (cfg_ff.cell_count),
      .cell_width   (cell_width),
      .cell_height  (cell_height),
      .busy         (cfg_busy)
   );

   // hold input items off while the cell size is being worked out
   assign div_in_valid = req_tvalid && !cfg_busy;
   assign req_tready   = div_in_ready && !cfg_busy;

   // column and row of the cell, one quotient bit per stage
   cgtp_div_pipe #(
      .COORD_BITS (COORD_BITS)
   ) u_div_pipe (
      .clock       (clock),
      .reset       (reset),
      .cell_width  (cell_width),
      .cell_height (cell_height),
      .in_valid    (div_in_valid),
      .in_ready    (div_in_ready),
      .in_x        (req_tdata[COORD_BITS-1:0]),
      .in_y        (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .out_valid   (div_out_valid),
      .out_ready   (div_out_ready),
      .out_x       (div_x),
      .out_y       (div_y),
      .out_col     (div_col),
      .out_row     (div_row)
   );

   // coverage, address and color, ending in the output register
   cgtp_color_pipe #(
      .COORD_BITS (COORD_BITS)
   ) u_color_pipe (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .cell_width  (cell_width),
      .cell_height (cell_height),
      .in_valid    (div_out_valid),
      .in_ready    (div_out_ready),
      .in_x        (div_x),
      .in_y        (div_y),
      .in_col      (div_col),
      .in_row      (div_row),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_covered (rsp_tuser),
      .out_address (rsp_address),
      .out_color   (rsp_color)
   );

   assign rsp_tdata = {rsp_color, rsp_address};

   // a write must block input until the cell size is fresh
   `CGTP_ASSERT_NEXT(a_write_blocks_input, csr_we, cfg_busy && !req_tready,
      "configuration write did not hold off input items")

   // uncovered pixels carry no color
   `CGTP_ASSERT(a_uncovered_black, (rsp_tvalid && !rsp_tuser) |-> (rsp_color == '0),
      "uncovered pixel has a nonzero color")

   // the finished cell width is the floor of the quotient
   `CGTP_ASSERT(a_cell_width_floor,
      (!cfg_busy && cfg_ff.cell_count != '0) |->
         ((CHECK_BITS'(cell_width) * CHECK_BITS'(cfg_ff.cell_count)
             <= CHECK_BITS'(cfg_ff.screen_width)) &&
          ((CHECK_BITS'(cell_width) + CHECK_BITS'(1)) * CHECK_BITS'(cfg_ff.cell_count)
             > CHECK_BITS'(cfg_ff.screen_width))),
      "cell width does not match resolution over cell count")

endmodule
